// File: hw/rtl/bmhq_pkg.sv
// Package for the binary min-heap queue unit.
// Default sizes, operation and status codes. No dependencies.
package bmhq_pkg;

	localparam int DEF_CAPACITY = 1024;
	localparam int DEF_KEY_BITS = 16;
	localparam int DEF_TAG_BITS = 10;

	localparam int COUNT_BITS  = 11;
	localparam int STATUS_BITS = 2;

	typedef enum logic {
		FN_PUSH = 1'b0,
		FN_POP  = 1'b1
	} func_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

// File: hw/rtl/binary_min_heap_queue_unit.sv
// Binary min-heap priority queue: heap memory, sift sequencer, output register.
// Depends on bmhq_pkg.
//
// Usage:
//   Slave stream (s_*) carries one operation per item: tuser is the operation
//   (push or pop), tdata holds key and tag of a pushed entry. Master stream
//   (m_*) returns exactly one item per operation: popped key and tag (zero
//   unless a pop succeeded), entry count in tdata, and status in tuser
//   (done, pop on empty, push on full). Failed operations leave the heap as is.
//   The heap sits in a single-port memory with registered read; a sequencer
//   moves a hole through it with one shared key comparator.
//   A push reads the parent, then compares and writes, for each level climbed,
//   with a final write when it reaches the root; a pop reads the root and the
//   last entry, then per level reads the left and right child, compares and
//   writes. A failed operation goes straight to the output register.
//   s_tready is high only while the sequencer is idle. A finished result
//   waits in the output register; the next item is accepted meanwhile, and the
//   sequencer holds its following result until the receiver takes the first.
//   Reset clears the entry count and the output valid; the memory needs no
//   clearing since only entries below the count are used.
module binary_min_heap_queue_unit
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int KEY_BITS = DEF_KEY_BITS,
	parameter int TAG_BITS = DEF_TAG_BITS,
	localparam int IN_W    = KEY_BITS + TAG_BITS,
	localparam int IN_DW   = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W   = KEY_BITS + TAG_BITS + COUNT_BITS,
	localparam int OUT_DW  = ((OUT_W + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DW-1:0]       s_tdata,  // entry_key, entry_tag
	input  logic                   s_tuser,  // func
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DW-1:0]      m_tdata,  // popped_key, popped_tag, entry_count
	output logic [STATUS_BITS-1:0] m_tuser   // status
);

	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IW    = AW + 2;

	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic [KEY_BITS-1:0] key;
	} ent_t;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_UP_RD   = 11'b000_0000_0010,
		S_UP_CMP  = 11'b000_0000_0100,
		S_UP_WR   = 11'b000_0000_1000,
		S_PD_RT   = 11'b000_0001_0000,
		S_PD_LAST = 11'b000_0010_0000,
		S_PD_LE   = 11'b000_0100_0000,
		S_DN_L    = 11'b000_1000_0000,
		S_DN_R    = 11'b001_0000_0000,
		S_DN_CMP  = 11'b010_0000_0000,
		S_DONE    = 11'b100_0000_0000
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [AW-1:0]        pos_q;
	ent_t                 ent_q;
	ent_t                 best_q;
	logic                 best_ch_q;
	logic                 best_l_q;
	logic                 has_r_q;
	ent_t                 res_q;
	status_t              res_st_q;
	logic                 ovalid_q;
	logic [OUT_DW-1:0]    odata_q;
	logic [STATUS_BITS-1:0] ouser_q;

	ent_t                 heap_q [CAPACITY];
	ent_t                 rd_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_addr;
	ent_t                 mem_wdata;

	logic [KEY_BITS-1:0]  cmp_a;
	logic [KEY_BITS-1:0]  cmp_b;
	logic                 lt;

	logic [AW-1:0]        parent;
	logic [IW-1:0]        lc;
	logic [IW-1:0]        rc;
	logic [IW-1:0]        n_ext;
	logic                 take_r;
	logic                 in_acc;
	logic                 out_free;
	logic [CNT_W+COUNT_BITS-1:0] cnt_ext;
	ent_t                 in_ent;

	assign in_ent.key = s_tdata[KEY_BITS-1:0];
	assign in_ent.tag = s_tdata[IN_W-1:KEY_BITS];

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	assign out_free = ~ovalid_q | m_tready;

	assign parent = AW'((pos_q - AW'(1)) >> 1);
	assign lc     = {1'b0, pos_q, 1'b1};
	assign rc     = lc + IW'(1);
	assign n_ext  = IW'(count_q);
	assign take_r = has_r_q & lt;
	assign cnt_ext = {{COUNT_BITS{1'b0}}, count_q};

	// shared key comparator
	always_comb begin
		cmp_a = rd_q.key;
		cmp_b = ent_q.key;
		unique case (state_q)
			S_UP_CMP: begin
				cmp_a = ent_q.key;
				cmp_b = rd_q.key;
			end
			S_DN_CMP: begin
				cmp_a = rd_q.key;
				cmp_b = best_q.key;
			end
			default: begin
				cmp_a = rd_q.key;
				cmp_b = ent_q.key;
			end
		endcase
	end
	assign lt = (cmp_a < cmp_b);

	// memory port
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = pos_q;
		mem_wdata = ent_q;
		unique case (state_q)
			S_UP_RD: mem_addr = parent;
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (lt) begin
					mem_wdata = rd_q;
				end
			end
			S_UP_WR: mem_we = 1'b1;
			S_PD_RT: mem_addr = '0;
			S_PD_LAST: mem_addr = AW'(count_q);
			S_DN_L: begin
				if (lc < n_ext) begin
					mem_addr = AW'(lc);
				end else begin
					mem_we = 1'b1;
				end
			end
			S_DN_R: mem_addr = AW'(rc);
			S_DN_CMP: begin
				mem_we = 1'b1;
				if (take_r) begin
					mem_wdata = rd_q;
				end else if (best_ch_q) begin
					mem_wdata = best_q;
				end
			end
			default: mem_addr = pos_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			heap_q[mem_addr] <= mem_wdata;
		end
		rd_q <= heap_q[mem_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (func_t'(s_tuser) == FN_PUSH) begin
							if (count_q == CNT_W'(CAPACITY)) begin
								state_q <= S_DONE;
							end else begin
								count_q <= count_q + CNT_W'(1);
								state_q <= (count_q == '0) ? S_UP_WR : S_UP_RD;
							end
						end else begin
							if (count_q == '0) begin
								state_q <= S_DONE;
							end else begin
								count_q <= count_q - CNT_W'(1);
								state_q <= S_PD_RT;
							end
						end
					end
				end
				S_UP_RD:   state_q <= S_UP_CMP;
				S_UP_CMP: begin
					if (lt) begin
						state_q <= (parent == '0) ? S_UP_WR : S_UP_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_UP_WR:   state_q <= S_DONE;
				S_PD_RT:   state_q <= S_PD_LAST;
				S_PD_LAST: state_q <= S_PD_LE;
				S_PD_LE:   state_q <= S_DN_L;
				S_DN_L:    state_q <= (lc < n_ext) ? S_DN_R : S_DONE;
				S_DN_R:    state_q <= S_DN_CMP;
				S_DN_CMP:  state_q <= (take_r || best_ch_q) ? S_DN_L : S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ent_q    <= in_ent;
				pos_q    <= AW'(count_q);
				res_q    <= '0;
				res_st_q <= ST_DONE;
				if (func_t'(s_tuser) == FN_PUSH) begin
					if (count_q == CNT_W'(CAPACITY)) begin
						res_st_q <= ST_FULL;
					end
				end else if (count_q == '0) begin
					res_st_q <= ST_EMPTY;
				end
			end
			S_UP_CMP: begin
				if (lt) begin
					pos_q <= parent;
				end
			end
			S_PD_LAST: res_q <= rd_q;
			S_PD_LE: begin
				ent_q <= rd_q;
				pos_q <= '0;
			end
			S_DN_R: begin
				best_ch_q <= lt;
				best_l_q  <= lt;
				best_q    <= lt ? rd_q : ent_q;
				has_r_q   <= (rc < n_ext);
			end
			S_DN_CMP: begin
				if (take_r) begin
					pos_q <= AW'(rc);
				end else if (best_ch_q && best_l_q) begin
					pos_q <= AW'(lc);
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			odata_q <= OUT_DW'({cnt_ext[COUNT_BITS-1:0], res_q.tag, res_q.key});
			ouser_q <= res_st_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = ouser_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser == FN_PUSH && count_q != CNT_W'(CAPACITY))
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("push did not grow the heap");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser == FN_POP && count_q != '0)
		|=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("pop did not shrink the heap");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_EMPTY || m_tuser == ST_FULL))
		|-> (m_tdata[KEY_BITS+TAG_BITS-1:0] == '0))
		else $error("failed operation returned an entry");

endmodule
